@@ hw/rtl/qalu_pkg.sv @@
`timescale 1ns / 1ps

package qalu_pkg;

    // Opcode values
    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_LT  = 4'd4;
    localparam logic [3:0] OP_GT  = 4'd5;
    localparam logic [3:0] OP_LE  = 4'd6;
    localparam logic [3:0] OP_GE  = 4'd7;
    localparam logic [3:0] OP_EQ  = 4'd8;
    localparam logic [3:0] OP_NE  = 4'd9;
    localparam logic [3:0] OP_MIN = 4'd10;
    localparam logic [3:0] OP_MAX = 4'd11;
    localparam logic [3:0] OP_INC = 4'd12;
    localparam logic [3:0] OP_DEC = 4'd13;

    localparam int unsigned RAW_W = 32;
    localparam logic signed [RAW_W-1:0] RAW_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [RAW_W-1:0] RAW_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [3:0]               opcode;
        logic signed [RAW_W-1:0]  operand_a;
        logic signed [RAW_W-1:0]  operand_b;
    } t_alu_in;

    typedef struct packed {
        logic signed [RAW_W-1:0]  result_value;
        logic                     compare_true;
        logic                     overflowed;
        logic                     divided_by_zero;
    } t_alu_out;

    // Sideband that rides along the divider stages
    typedef struct packed {
        logic                     is_div;
        logic                     q_neg;
        logic                     a_neg;
        logic                     a_zero;
        logic                     b_zero;
        logic signed [RAW_W-1:0]  value;
        logic                     cmp;
        logic                     ov;
    } t_side;

endpackage

@@ hw/rtl/qalu_pre.sv @@
`timescale 1ns / 1ps

module qalu_pre import qalu_pkg::*; #(
    parameter int FRAC_BITS = 8,
    parameter int NUM_W     = RAW_W + FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_alu_in           i_cmd,
    output logic              o_valid,
    output t_side             o_side,
    output logic [NUM_W-1:0]  o_num,
    output logic [RAW_W-1:0]  o_den
);

    // Stage 1 registers
    logic                     r_v1;
    logic [3:0]               r_op1;
    logic signed [RAW_W-1:0]  r_a1;
    logic signed [RAW_W-1:0]  r_b1;
    logic signed [63:0]       r_prod1;
    logic signed [63:0]       n_prod1;

    // Stage 2 registers
    logic                     r_v2;
    t_side                    r_side2;
    t_side                    n_side2;
    logic [NUM_W-1:0]         r_num2;
    logic [RAW_W-1:0]         r_den2;

    // Multiply on the raw values
    assign n_prod1 = i_cmd.operand_a * i_cmd.operand_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_op1   <= i_cmd.opcode;
        r_a1    <= i_cmd.operand_a;
        r_b1    <= i_cmd.operand_b;
        r_prod1 <= n_prod1;
    end

    // Round, saturate and evaluate every op but the divide, which only sets is_div
    logic signed [63:0] w_bias;
    logic signed [63:0] w_rnd;
    logic              w_pneg;
    logic              w_rnd_fits;
    logic [RAW_W:0]    w_sum;
    logic [RAW_W:0]    w_dif;
    logic [RAW_W-1:0]  w_amag;
    logic [RAW_W-1:0]  w_bmag;

    // Round half away from zero: add one half, one LSB less when negative,
    // then shift arithmetically
    assign w_pneg     = r_prod1[63];
    assign w_bias     = r_prod1 + (64'd1 << (FRAC_BITS - 1)) - {63'd0, w_pneg};
    assign w_rnd      = w_bias >>> FRAC_BITS;
    assign w_rnd_fits = (&w_rnd[63:31]) || !(|w_rnd[63:31]);
    assign w_sum  = {r_a1[RAW_W-1], r_a1} + {r_b1[RAW_W-1], r_b1};
    assign w_dif  = {r_a1[RAW_W-1], r_a1} - {r_b1[RAW_W-1], r_b1};
    assign w_amag = r_a1[RAW_W-1] ? (~r_a1 + 1'b1) : r_a1;
    assign w_bmag = r_b1[RAW_W-1] ? (~r_b1 + 1'b1) : r_b1;

    always_comb begin
        n_side2        = '0;
        n_side2.q_neg  = r_a1[RAW_W-1] ^ r_b1[RAW_W-1];
        n_side2.a_neg  = r_a1[RAW_W-1];
        n_side2.a_zero = (r_a1 == '0);
        n_side2.b_zero = (r_b1 == '0);
        case (r_op1)
            OP_ADD: begin
                n_side2.ov    = w_sum[RAW_W] ^ w_sum[RAW_W-1];
                n_side2.value = n_side2.ov ? (w_sum[RAW_W] ? RAW_MIN : RAW_MAX)
                                           : w_sum[RAW_W-1:0];
            end
            OP_SUB: begin
                n_side2.ov    = w_dif[RAW_W] ^ w_dif[RAW_W-1];
                n_side2.value = n_side2.ov ? (w_dif[RAW_W] ? RAW_MIN : RAW_MAX)
                                           : w_dif[RAW_W-1:0];
            end
            OP_MUL: begin
                n_side2.ov    = !w_rnd_fits;
                n_side2.value = n_side2.ov ? (w_pneg ? RAW_MIN : RAW_MAX)
                                           : w_rnd[31:0];
            end
            OP_DIV: n_side2.is_div = 1'b1;
            OP_LT:  n_side2.cmp = (r_a1 <  r_b1);
            OP_GT:  n_side2.cmp = (r_a1 >  r_b1);
            OP_LE:  n_side2.cmp = (r_a1 <= r_b1);
            OP_GE:  n_side2.cmp = (r_a1 >= r_b1);
            OP_EQ:  n_side2.cmp = (r_a1 == r_b1);
            OP_NE:  n_side2.cmp = (r_a1 != r_b1);
            OP_MIN: n_side2.value = (r_a1 < r_b1) ? r_a1 : r_b1;
            OP_MAX: n_side2.value = (r_a1 > r_b1) ? r_a1 : r_b1;
            OP_INC: begin
                n_side2.ov    = (r_a1 == RAW_MAX);
                n_side2.value = n_side2.ov ? RAW_MAX : (r_a1 + 1'b1);
            end
            OP_DEC: begin
                n_side2.ov    = (r_a1 == RAW_MIN);
                n_side2.value = n_side2.ov ? RAW_MIN : (r_a1 - 1'b1);
            end
            default: n_side2.cmp = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_side2 <= n_side2;
        r_num2  <= {w_amag, {FRAC_BITS{1'b0}}};
        r_den2  <= w_bmag;
    end

    assign o_valid = r_v2;
    assign o_side  = r_side2;
    assign o_num   = r_num2;
    assign o_den   = r_den2;

endmodule

@@ hw/rtl/qalu_div.sv @@
`timescale 1ns / 1ps

module qalu_div import qalu_pkg::*; #(
    parameter int NUM_W = 40
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_side             i_side,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [RAW_W-1:0]  i_den,
    output logic              o_valid,
    output t_side             o_side,
    output logic [NUM_W-1:0]  o_quo,
    output logic [RAW_W-1:0]  o_rem,
    output logic [RAW_W-1:0]  o_den
);

    logic              w_vld  [0:NUM_W];
    t_side             w_side [0:NUM_W];
    logic [NUM_W-1:0]  w_num  [0:NUM_W];
    logic [NUM_W-1:0]  w_quo  [0:NUM_W];
    logic [RAW_W-1:0]  w_rem  [0:NUM_W];
    logic [RAW_W-1:0]  w_den  [0:NUM_W];

    assign w_vld[0]  = i_valid;
    assign w_side[0] = i_side;
    assign w_num[0]  = i_num;
    assign w_quo[0]  = '0;
    assign w_rem[0]  = '0;
    assign w_den[0]  = i_den;

    // One quotient bit per stage, restoring form
    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic              r_vld;
        t_side             r_side;
        logic [NUM_W-1:0]  r_num;
        logic [NUM_W-1:0]  r_quo;
        logic [RAW_W-1:0]  r_rem;
        logic [RAW_W-1:0]  r_den;
        logic [RAW_W:0]    w_sh;
        logic [RAW_W:0]    w_sub;
        logic              w_ge;

        assign w_sh  = {w_rem[k], w_num[k][NUM_W-1]};
        assign w_sub = w_sh - {1'b0, w_den[k]};
        assign w_ge  = (w_sh >= {1'b0, w_den[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_vld[k];
            end
            r_side <= w_side[k];
            r_num  <= w_num[k] << 1;
            r_quo  <= {w_quo[k][NUM_W-2:0], w_ge};
            r_rem  <= w_ge ? w_sub[RAW_W-1:0] : w_sh[RAW_W-1:0];
            r_den  <= w_den[k];
        end

        assign w_vld[k+1]  = r_vld;
        assign w_side[k+1] = r_side;
        assign w_num[k+1]  = r_num;
        assign w_quo[k+1]  = r_quo;
        assign w_rem[k+1]  = r_rem;
        assign w_den[k+1]  = r_den;
    end

    assign o_valid = w_vld[NUM_W];
    assign o_side  = w_side[NUM_W];
    assign o_quo   = w_quo[NUM_W];
    assign o_rem   = w_rem[NUM_W];
    assign o_den   = w_den[NUM_W];

endmodule

@@ hw/rtl/qalu_post.sv @@
`timescale 1ns / 1ps

module qalu_post import qalu_pkg::*; #(
    parameter int NUM_W = 40
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_side             i_side,
    input  logic [NUM_W-1:0]  i_quo,
    input  logic [RAW_W-1:0]  i_rem,
    input  logic [RAW_W-1:0]  i_den,
    output logic              o_valid,
    output t_alu_out          o_result
);

    logic      r_valid;
    t_alu_out  r_result;
    t_alu_out  n_result;
    logic [NUM_W:0]  w_qr;
    logic            w_up;

    // Round half away from zero on the magnitude
    assign w_up = ({i_rem, 1'b0} >= {1'b0, i_den});
    assign w_qr = {1'b0, i_quo} + {{NUM_W{1'b0}}, w_up};

    always_comb begin
        n_result              = '0;
        n_result.result_value = i_side.value;
        n_result.compare_true = i_side.cmp;
        n_result.overflowed   = i_side.ov;
        if (i_side.is_div) begin
            n_result.compare_true = 1'b0;
            if (i_side.b_zero) begin
                n_result.divided_by_zero = 1'b1;
                n_result.overflowed      = !i_side.a_zero;
                n_result.result_value    = i_side.a_zero ? '0
                                         : (i_side.a_neg ? RAW_MIN : RAW_MAX);
            end else if (i_side.q_neg) begin
                n_result.overflowed = (|w_qr[NUM_W:RAW_W])
                                   || (w_qr[RAW_W-1] && (|w_qr[RAW_W-2:0]));
                n_result.result_value = n_result.overflowed ? RAW_MIN
                                      : (~w_qr[RAW_W-1:0] + 1'b1);
            end else begin
                n_result.overflowed   = |w_qr[NUM_W:RAW_W-1];
                n_result.result_value = n_result.overflowed ? RAW_MAX
                                      : w_qr[RAW_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ hw/rtl/fixed_point_q24_8_alu.sv @@
`timescale 1ns / 1ps

// Signed fixed-point ALU on 32-bit raw values with FRAC_BITS fraction bits.
// Command channel: drive i_cmd and raise start; a beat is taken at every
// rising edge where start is high and busy is low. busy is always low, so
// a new beat may be issued every cycle.
// Result channel: o_result holds one beat for exactly one cycle, marked by
// o_valid. Every command yields one result, in command order.
// Path: qalu_pre, then qalu_div, then qalu_post (Q24.8 for the default
// FRAC_BITS of 8). The depth is set by the divider, which resolves one
// quotient bit per stage over 32 + FRAC_BITS stages; every opcode runs
// through the same depth so results stay in order.
// Throughput: one command per cycle for every opcode mix.
// Reset: synchronous, active low; clears all stage valid bits, so no
// result beat appears after reset until new commands enter.
// The receiver cannot stall; results must be captured when o_valid is high.
module fixed_point_q24_8_alu import qalu_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_alu_in   i_cmd,
    output logic      o_valid,
    output t_alu_out  o_result
);

    localparam int NUM_W = RAW_W + FRAC_BITS;

    logic              w_pre_vld;
    t_side             w_pre_side;
    logic [NUM_W-1:0]  w_pre_num;
    logic [RAW_W-1:0]  w_pre_den;
    logic              w_div_vld;
    t_side             w_div_side;
    logic [NUM_W-1:0]  w_div_quo;
    logic [RAW_W-1:0]  w_div_rem;
    logic [RAW_W-1:0]  w_div_den;

    // Fully pipelined: never hold off a command
    assign busy = 1'b0;

    qalu_pre #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W)) u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_cmd   (i_cmd),
        .o_valid (w_pre_vld),
        .o_side  (w_pre_side),
        .o_num   (w_pre_num),
        .o_den   (w_pre_den)
    );

    qalu_div #(.NUM_W(NUM_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pre_vld),
        .i_side  (w_pre_side),
        .i_num   (w_pre_num),
        .i_den   (w_pre_den),
        .o_valid (w_div_vld),
        .o_side  (w_div_side),
        .o_quo   (w_div_quo),
        .o_rem   (w_div_rem),
        .o_den   (w_div_den)
    );

    qalu_post #(.NUM_W(NUM_W)) u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_div_vld),
        .i_side   (w_div_side),
        .i_quo    (w_div_quo),
        .i_rem    (w_div_rem),
        .i_den    (w_div_den),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
